>>> hdl/slt_pkg.sv
// Shared types and constants for the slot table with free-list stack.
package slt_pkg;

  localparam int unsigned SlotsDefault = 64;
  localparam int unsigned WordW        = 64;
  localparam int unsigned HandleW      = 6;
  localparam int unsigned CountW       = 7;
  localparam int unsigned ActW         = 2;
  localparam int unsigned StatW        = 2;
  localparam int unsigned InDataW      = 72;
  localparam int unsigned OutDataW     = 80;

  localparam logic [ActW-1:0] ACT_INSERT = 2'd0;
  localparam logic [ActW-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ActW-1:0] ACT_CLEAR  = 2'd2;
  localparam logic [ActW-1:0] ACT_LIST   = 2'd3;

  localparam logic [StatW-1:0] ST_OK      = 2'd0;
  localparam logic [StatW-1:0] ST_FULL    = 2'd1;
  localparam logic [StatW-1:0] ST_IGNORED = 2'd2;
  localparam logic [StatW-1:0] ST_NONE    = 2'd3;

  typedef struct packed {
    logic [StatW-1:0]   status;
    logic [HandleW-1:0] handle;
    logic [WordW-1:0]   word;
    logic [CountW-1:0]  live;
    logic               last;
  } res_t;

endpackage

>>> hdl/slt_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
module slt_ram import slt_pkg::*; #(
  parameter int unsigned Width = WordW,
  parameter int unsigned Depth = SlotsDefault,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next enabled read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/slt_out_reg.sv
// Output holding register for result transfers.
module slt_out_reg import slt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  res_t res_i,
  output logic free_o,
  output logic valid_o,
  input  logic ready_i,
  output res_t res_o
);

  logic valid_q, valid_d;
  res_t res_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i ? 1'b1 : (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

>>> hdl/slot_table_free_list_core.sv
// Slot table top level: command sequencer, occupancy flags, word and free-stack memories.
//
//  channel | dir | tdata (low bit up)                          | tuser  | tlast
//  s_axis  | in  | user_word[63:0], slot_handle[69:64]         | action | -
//  m_axis  | out | out_handle[5:0], out_word[69:6], live[76:70] | status | last
//
// Insert runs through EXEC and EMIT, and through POP as well when the handle is popped
// from the free stack (registered read of the stack memory). Remove and clear run EXEC and EMIT.
// List scans each index up to the last occupied one, reading the word of each occupied index;
// an empty list scans the whole used extent and then emits a none result.
// Reset clears flags and counters at once; no memory clearing pass.
// A stalled output holds the sequencer before it loads its next result.
module slot_table_free_list_core import slt_pkg::*; #(
  parameter int unsigned SLOTS = SlotsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,   // user_word[63:0], slot_handle[69:64]
  input  logic [ActW-1:0]     s_axis_tuser_i,   // action[1:0]
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o,   // out_handle[5:0], out_word[69:6], live[76:70]
  output logic [StatW-1:0]    m_axis_tuser_o,   // status[1:0]
  output logic                m_axis_tlast_o
);

  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [CountW-1:0] SlotsCnt = CountW'(SLOTS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_POP   = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_LOUT  = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0]         state_q, state_d;
  logic [SLOTS-1:0]   occ_q, occ_d;
  logic [CountW-1:0]  depth_q, depth_d;
  logic [CountW-1:0]  extent_q, extent_d;
  logic [CountW-1:0]  live_q, live_d;
  logic [CountW-1:0]  idx_q, idx_d;
  logic               found_q, found_d;
  logic [ActW-1:0]    act_q;
  logic [WordW-1:0]   word_q;
  logic [HandleW-1:0] hdl_q;
  res_t               res_q, res_d;

  logic               accept;
  logic               out_free, out_load;
  res_t               out_res, out_data;
  logic               wm_we, wm_re;
  logic [AW-1:0]      wm_waddr, wm_raddr;
  logic [WordW-1:0]   wm_rdata;
  logic               sm_we, sm_re;
  logic [AW-1:0]      sm_waddr, sm_raddr;
  logic [AW-1:0]      sm_rdata;
  logic [SLOTS-1:0]   occ_above;
  logic               list_last;

  // no transfer is taken while reset is held
  assign s_axis_tready_o = rst_ni && (state_q == S_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign occ_above = (occ_q >> idx_q[AW-1:0]) >> 1;
  assign list_last = (occ_above == '0);

  always_comb begin
    state_d  = state_q;
    occ_d    = occ_q;
    depth_d  = depth_q;
    extent_d = extent_q;
    live_d   = live_q;
    idx_d    = idx_q;
    found_d  = found_q;
    res_d    = res_q;
    wm_we    = 1'b0;
    wm_waddr = extent_q[AW-1:0];
    wm_re    = 1'b0;
    wm_raddr = idx_q[AW-1:0];
    sm_we    = 1'b0;
    sm_waddr = depth_q[AW-1:0];
    sm_re    = 1'b0;
    sm_raddr = AW'(depth_q - CountW'(1));
    out_load = 1'b0;
    out_res  = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        res_d = '0;
        res_d.last = 1'b1;
        state_d = S_EMIT;
        case (act_q)
          ACT_INSERT: begin
            if (depth_q != '0) begin
              sm_re   = 1'b1;
              depth_d = depth_q - CountW'(1);
              state_d = S_POP;
            end else if (extent_q < SlotsCnt) begin
              wm_we    = 1'b1;
              occ_d[extent_q[AW-1:0]] = 1'b1;
              extent_d = extent_q + CountW'(1);
              live_d   = live_q + CountW'(1);
              res_d.handle = HandleW'(extent_q);
              res_d.live   = live_q + CountW'(1);
            end else begin
              res_d.status = ST_FULL;
              res_d.live   = live_q;
            end
          end
          ACT_REMOVE: begin
            if (({1'b0, hdl_q} < extent_q) && occ_q[hdl_q[AW-1:0]]) begin
              occ_d[hdl_q[AW-1:0]] = 1'b0;
              sm_we   = 1'b1;
              depth_d = depth_q + CountW'(1);
              live_d  = live_q - CountW'(1);
              res_d.live = live_q - CountW'(1);
            end else begin
              res_d.status = ST_IGNORED;
              res_d.live   = live_q;
            end
          end
          ACT_CLEAR: begin
            occ_d    = '0;
            depth_d  = '0;
            extent_d = '0;
            live_d   = '0;
          end
          default: begin
            idx_d   = '0;
            found_d = 1'b0;
            state_d = S_SCAN;
          end
        endcase
      end
      S_POP: begin
        wm_we    = 1'b1;
        wm_waddr = sm_rdata;
        occ_d[sm_rdata] = 1'b1;
        live_d   = live_q + CountW'(1);
        res_d    = '0;
        res_d.handle = HandleW'(sm_rdata);
        res_d.live   = live_q + CountW'(1);
        res_d.last   = 1'b1;
        state_d  = S_EMIT;
      end
      S_SCAN: begin
        if (idx_q >= extent_q) begin
          if (found_q) begin
            state_d = S_IDLE;
          end else begin
            res_d        = '0;
            res_d.status = ST_NONE;
            res_d.live   = live_q;
            res_d.last   = 1'b1;
            state_d      = S_EMIT;
          end
        end else if (occ_q[idx_q[AW-1:0]]) begin
          wm_re   = 1'b1;
          state_d = S_LOUT;
        end else begin
          idx_d = idx_q + CountW'(1);
        end
      end
      S_LOUT: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_res.status = ST_OK;
          out_res.handle = HandleW'(idx_q);
          out_res.word   = wm_rdata;
          out_res.live   = live_q;
          out_res.last   = list_last;
          found_d        = 1'b1;
          idx_d          = idx_q + CountW'(1);
          state_d        = list_last ? S_IDLE : S_SCAN;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          out_res  = res_q;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      occ_q    <= '0;
      depth_q  <= '0;
      extent_q <= '0;
      live_q   <= '0;
      idx_q    <= '0;
      found_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      occ_q    <= occ_d;
      depth_q  <= depth_d;
      extent_q <= extent_d;
      live_q   <= live_d;
      idx_q    <= idx_d;
      found_q  <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (accept) begin
      act_q  <= s_axis_tuser_i;
      word_q <= s_axis_tdata_i[WordW-1:0];
      hdl_q  <= s_axis_tdata_i[WordW +: HandleW];
    end
  end

  slt_ram #(
    .Width (WordW),
    .Depth (SLOTS)
  ) u_word_mem (
    .clk_i   (clk_i),
    .we_i    (wm_we),
    .waddr_i (wm_waddr),
    .wdata_i (word_q),
    .re_i    (wm_re),
    .raddr_i (wm_raddr),
    .rdata_o (wm_rdata)
  );

  slt_ram #(
    .Width (AW),
    .Depth (SLOTS)
  ) u_stack_mem (
    .clk_i   (clk_i),
    .we_i    (sm_we),
    .waddr_i (sm_waddr),
    .wdata_i (hdl_q[AW-1:0]),
    .re_i    (sm_re),
    .raddr_i (sm_raddr),
    .rdata_o (sm_rdata)
  );

  slt_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (out_load),
    .res_i   (out_res),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .res_o   (out_data)
  );

  assign m_axis_tdata_o = {{(OutDataW - HandleW - WordW - CountW){1'b0}},
                           out_data.live, out_data.word, out_data.handle};
  assign m_axis_tuser_o = out_data.status;
  assign m_axis_tlast_o = out_data.last;

endmodule

>>> bench/slot_table_free_list_core_tb.sv
// Testbench for slot_table_free_list_core: directed table, random command phases, scoreboard.
module slot_table_free_list_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import slt_pkg::*;

  localparam int unsigned Slots     = SlotsDefault;
  localparam int unsigned IdleLimit = 4000;
  localparam int unsigned RandItems = 300;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata = '0;
  logic [ActW-1:0]     s_tuser = ACT_INSERT;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic [StatW-1:0]    m_tuser;
  logic                m_tlast;

  slot_table_free_list_core #(.SLOTS(Slots)) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // shadow of the handle table
  logic [WordW-1:0]   slot_word [Slots];
  logic               slot_busy [Slots];
  logic [HandleW-1:0] free_lifo [Slots];
  int unsigned        free_top;
  int unsigned        extent;
  logic [CountW-1:0]  live_cnt;

  res_t        pending_results [$];
  int unsigned fail_cnt;
  int unsigned cmds_accepted;
  bit          gaps_off;

  function automatic res_t mk_res(logic [StatW-1:0] st, logic [HandleW-1:0] h,
                                  logic [WordW-1:0] w, logic [CountW-1:0] lv, logic lst);
    res_t r;
    r.status = st;
    r.handle = h;
    r.word   = w;
    r.live   = lv;
    r.last   = lst;
    return r;
  endfunction

  // Apply one command to the shadow table; queue its results when record is set.
  function automatic void table_apply(logic [ActW-1:0] act, logic [WordW-1:0] w,
                                      logic [HandleW-1:0] h, bit record);
    int unsigned idx;
    int unsigned hits;
    res_t        r [$];
    hits = 0;
    case (act)
      ACT_INSERT: begin
        if (free_top > 0) begin
          free_top--;
          idx = free_lifo[free_top];
        end else if (extent < Slots) begin
          idx = extent;
          extent++;
        end else begin
          idx = Slots;
        end
        if (idx == Slots) begin
          r = {r, mk_res(ST_FULL, '0, '0, live_cnt, 1'b1)};
        end else begin
          slot_word[idx] = w;
          slot_busy[idx] = 1'b1;
          live_cnt++;
          r = {r, mk_res(ST_OK, HandleW'(idx), '0, live_cnt, 1'b1)};
        end
      end
      ACT_REMOVE: begin
        if (h < extent && slot_busy[h]) begin
          slot_busy[h] = 1'b0;
          slot_word[h] = '0;
          free_lifo[free_top] = h;
          free_top++;
          live_cnt--;
          r = {r, mk_res(ST_OK, '0, '0, live_cnt, 1'b1)};
        end else begin
          r = {r, mk_res(ST_IGNORED, '0, '0, live_cnt, 1'b1)};
        end
      end
      ACT_CLEAR: begin
        for (int i = 0; i < Slots; i++) slot_busy[i] = 1'b0;
        free_top = 0;
        extent   = 0;
        live_cnt = '0;
        r = {r, mk_res(ST_OK, '0, '0, live_cnt, 1'b1)};
      end
      default: begin
        for (int i = 0; i < extent; i++) begin
          if (slot_busy[i]) begin
            r = {r, mk_res(ST_OK, HandleW'(i), slot_word[i], live_cnt, 1'b0)};
            hits++;
          end
        end
        if (hits == 0) r = {r, mk_res(ST_NONE, '0, '0, live_cnt, 1'b1)};
        else r[hits-1].last = 1'b1;
      end
    endcase
    if (record) begin
      pending_results = {pending_results, r};
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (gaps_off || r < 60) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one command and wait for its transfer; typed rows carry their own result.
  task automatic push_cmd(logic [ActW-1:0] act, logic [WordW-1:0] w, logic [HandleW-1:0] h,
                          bit typed, res_t exp_res);
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, h, w};
    s_tuser  <= act;
    do @(posedge clk_i); while (!s_tready);
    cmds_accepted++;
    table_apply(act, w, h, !typed);
    if (typed) pending_results = {pending_results, exp_res};
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  function automatic logic [HandleW-1:0] pick_live();
    int unsigned i;
    do i = $urandom_range(0, extent - 1); while (!slot_busy[i]);
    return HandleW'(i);
  endfunction

  function automatic logic [WordW-1:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  typedef struct {
    logic [ActW-1:0]    act;
    logic [WordW-1:0]   w;
    logic [HandleW-1:0] h;
    bit                 typed;
    res_t               exp_res;
  } cmd_row_t;

  cmd_row_t directed_rows [$];

  task automatic add_row(logic [ActW-1:0] act, logic [WordW-1:0] w, logic [HandleW-1:0] h,
                         bit typed, res_t exp_res);
    cmd_row_t row;
    row.act     = act;
    row.w       = w;
    row.h       = h;
    row.typed   = typed;
    row.exp_res = exp_res;
    directed_rows = {directed_rows, row};
  endtask

  // stimulus
  initial begin
    int unsigned rand_done;
    int unsigned phase_len;
    int unsigned pick;
    res_t        none_r;
    none_r = '0;
    free_top = 0;
    extent   = 0;
    live_cnt = '0;
    fail_cnt = 0;
    cmds_accepted = 0;
    gaps_off = 1'b0;
    for (int i = 0; i < Slots; i++) slot_busy[i] = 1'b0;

    add_row(ACT_LIST,   '0,    '0,    1, mk_res(ST_NONE,    '0, '0, 7'd0, 1'b1));
    add_row(ACT_REMOVE, '0,    6'd0,  1, mk_res(ST_IGNORED, '0, '0, 7'd0, 1'b1));
    add_row(ACT_REMOVE, '1,    6'd63, 1, mk_res(ST_IGNORED, '0, '0, 7'd0, 1'b1));
    add_row(ACT_INSERT, '1,    6'd63, 1, mk_res(ST_OK, 6'd0, '0, 7'd1, 1'b1));
    add_row(ACT_INSERT, '0,    '0,    1, mk_res(ST_OK, 6'd1, '0, 7'd2, 1'b1));
    add_row(ACT_INSERT, 64'h5a5a_a5a5_0f0f_f0f0, 6'd42, 1, mk_res(ST_OK, 6'd2, '0, 7'd3, 1'b1));
    add_row(ACT_LIST,   '0,    '0,    0, none_r);
    add_row(ACT_REMOVE, '0,    6'd1,  1, mk_res(ST_OK,      '0, '0, 7'd2, 1'b1));
    add_row(ACT_REMOVE, '0,    6'd1,  1, mk_res(ST_IGNORED, '0, '0, 7'd2, 1'b1));
    add_row(ACT_REMOVE, '0,    6'd3,  1, mk_res(ST_IGNORED, '0, '0, 7'd2, 1'b1));
    add_row(ACT_REMOVE, '0,    6'd0,  1, mk_res(ST_OK,      '0, '0, 7'd1, 1'b1));
    add_row(ACT_REMOVE, '1,    6'd2,  1, mk_res(ST_OK,      '0, '0, 7'd0, 1'b1));
    add_row(ACT_LIST,   '1,    '1,    1, mk_res(ST_NONE,    '0, '0, 7'd0, 1'b1));
    // freed handles come back last-freed first
    add_row(ACT_INSERT, 64'h0123_4567_89ab_cdef, '0, 0, none_r);
    add_row(ACT_INSERT, 64'hfedc_ba98_7654_3210, '0, 0, none_r);
    add_row(ACT_INSERT, 64'h8000_0000_0000_0000, '0, 0, none_r);
    add_row(ACT_INSERT, 64'h0000_0000_0000_0001, '0, 0, none_r);
    add_row(ACT_LIST,   '0,    '0,    0, none_r);
    add_row(ACT_CLEAR,  '1,    '1,    1, mk_res(ST_OK,      '0, '0, 7'd0, 1'b1));
    add_row(ACT_LIST,   '0,    '0,    1, mk_res(ST_NONE,    '0, '0, 7'd0, 1'b1));
    add_row(ACT_REMOVE, '0,    6'd0,  1, mk_res(ST_IGNORED, '0, '0, 7'd0, 1'b1));
    add_row(ACT_INSERT, 64'h8000_0000_0000_0001, '0, 1, mk_res(ST_OK, 6'd0, '0, 7'd1, 1'b1));
    add_row(ACT_LIST,   '0,    '0,    0, none_r);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      push_cmd(directed_rows[i].act, directed_rows[i].w, directed_rows[i].h,
               directed_rows[i].typed, directed_rows[i].exp_res);
    drain_results();

    // fill to the brim, knock on a full table, list all entries
    rand_done = 0;
    while (!(extent == Slots && free_top == 0)) begin
      push_cmd(ACT_INSERT, rand_word(), HandleW'($urandom()), 0, none_r);
      rand_done++;
    end
    repeat (3) begin
      push_cmd(ACT_INSERT, rand_word(), HandleW'($urandom()), 0, none_r);
      rand_done++;
    end
    push_cmd(ACT_LIST, rand_word(), HandleW'($urandom()), 0, none_r);
    rand_done++;
    drain_results();

    while (rand_done < RandItems) begin
      gaps_off = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        // refill phase: drive the table full again
        while (!(extent == Slots && free_top == 0)) begin
          push_cmd(ACT_INSERT, rand_word(), HandleW'($urandom()), 0, none_r);
          rand_done++;
        end
        push_cmd(ACT_INSERT, rand_word(), HandleW'($urandom()), 0, none_r);
        rand_done++;
      end else begin
        phase_len = $urandom_range(15, 40);
        repeat (phase_len) begin
          pick = $urandom_range(0, 99);
          if (pick < 45 || (pick < 75 && live_cnt == 0))
            push_cmd(ACT_INSERT, rand_word(), HandleW'($urandom()), 0, none_r);
          else if (pick < 75)
            push_cmd(ACT_REMOVE, rand_word(), pick_live(), 0, none_r);
          else if (pick < 87)
            push_cmd(ACT_REMOVE, rand_word(), HandleW'($urandom_range(0, 63)), 0, none_r);
          else if (pick < 96)
            push_cmd(ACT_LIST, rand_word(), HandleW'($urandom()), 0, none_r);
          else
            push_cmd(ACT_CLEAR, rand_word(), HandleW'($urandom()), 0, none_r);
          rand_done++;
        end
      end
      if ($urandom_range(0, 1) == 0) drain_results();
    end

    drain_results();
    repeat (50) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // result sink with random back-pressure and one long hold-off
  initial begin
    int unsigned r;
    bit          long_done;
    long_done = 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      r = $urandom_range(0, 99);
      if (!long_done && cmds_accepted >= 150) begin
        m_tready <= 1'b0;
        repeat (600) @(posedge clk_i);
        long_done = 1'b1;
      end else if (r < 50) begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end else if (r < 90) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end else if (r < 97) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(5, 30)) @(posedge clk_i);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(40, 100)) @(posedge clk_i);
      end
    end
  end

  // scoreboard: every result transfer against the oldest expectation
  always @(posedge clk_i) begin
    res_t exp_res;
    if (rst_ni && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d handle %0d", m_tuser, m_tdata[5:0]);
        fail_cnt++;
      end else begin
        exp_res = pending_results.pop_front();
        if (m_tuser !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, m_tuser);
          fail_cnt++;
        end
        if (m_tdata[5:0] !== exp_res.handle) begin
          $error("out_handle: expected %0d, got %0d", exp_res.handle, m_tdata[5:0]);
          fail_cnt++;
        end
        if (m_tdata[69:6] !== exp_res.word) begin
          $error("out_word: expected %h, got %h", exp_res.word, m_tdata[69:6]);
          fail_cnt++;
        end
        if (m_tdata[76:70] !== exp_res.live) begin
          $error("live_entries: expected %0d, got %0d", exp_res.live, m_tdata[76:70]);
          fail_cnt++;
        end
        if (m_tlast !== exp_res.last) begin
          $error("last: expected %0d, got %0d", exp_res.last, m_tlast);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    int unsigned idle_cycles;
    if (rst_ni) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("[FAIL] regression broken");
          $finish;
        end
      end
    end else begin
      idle_cycles = 0;
    end
  end

endmodule

>>> files.f
hdl/slt_pkg.sv
hdl/slt_ram.sv
hdl/slt_out_reg.sv
hdl/slot_table_free_list_core.sv
bench/slot_table_free_list_core_tb.sv
